@@ rtl/screen_point_unproject_ray_assert.svh @@
// Assertion macros shared by the RTL, checked on the rising clock edge
// and switched off while reset is high.
`ifndef SCREEN_POINT_UNPROJECT_RAY_ASSERT_SVH
`define SCREEN_POINT_UNPROJECT_RAY_ASSERT_SVH

// Same-cycle implication
`define SPU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define SPU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/spu_pkg.sv @@
package spu_pkg;

   // Input and matrix formats
   localparam int IN_W       = 17;
   localparam int SX_W       = 19;
   localparam int WORD_W     = 32;
   localparam int SCREEN_ONE = 65536;
   localparam int ONE_SHIFT  = 16;

   // Exact sums and their magnitudes
   localparam int SUM_W = 52;
   localparam int MAG_W = 52;

   // Quotient bits below the saturation point
   localparam int Q_BITS = 31;

   // Configuration registers
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 64;

   // Queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   // Payload packing
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 192;

   localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

   // Matrix words M[row][col]
   typedef logic [3:0][3:0][WORD_W-1:0] mat_type;

   // One classified point pair on its way to the dividers
   typedef struct packed {
      logic [3:0][SUM_W-1:0] far_sum;
      logic [3:0][SUM_W-1:0] near_sum;
      logic                  fault;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

@@ rtl/spu_front.sv @@
module spu_front
   import spu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mat_type          mat,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  norm_x,
   input  logic [IN_W-1:0]  norm_y,
   input  q_stat_type       q_stat,
   output logic             push,
   output entry_type        entry
);

   localparam int PROD_W = WORD_W + SX_W;

   logic                      en;
   logic                      a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic signed [SX_W-1:0]    sx_ff, sy_ff;
   logic signed [SX_W-1:0]    sx_in, sy_in;
   logic signed [PROD_W-1:0]  p0_ff [4];
   logic signed [PROD_W-1:0]  p1_ff [4];
   logic [3:0][SUM_W-1:0]     far_ff, near_ff;
   logic [3:0][SUM_W-1:0]     far_in, near_in;
   entry_type                 entry_ff;

   // whole front holds while the queue cannot take the finished entry
   assign en         = !(d_valid_ff && q_stat.full);
   assign req_tready = en;
   assign push       = d_valid_ff && !q_stat.full;
   assign entry      = entry_ff;

   // map 0..1 to -1..1
   assign sx_in = $signed({1'b0, norm_x, 1'b0}) - SX_W'(SCREEN_ONE);
   assign sy_in = $signed({1'b0, norm_y, 1'b0}) - SX_W'(SCREEN_ONE);

   // row 3 and row 2 terms scaled by 1.0, then the exact sums
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         far_in[c] = SUM_W'(p0_ff[c]) + SUM_W'(p1_ff[c])
                   + {{(SUM_W-WORD_W-ONE_SHIFT){mat[3][c][WORD_W-1]}}, mat[3][c],
                      {ONE_SHIFT{1'b0}}};
         near_in[c] = far_in[c]
                   + {{(SUM_W-WORD_W-ONE_SHIFT){mat[2][c][WORD_W-1]}}, mat[2][c],
                      {ONE_SHIFT{1'b0}}};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // payload stages: screen coords, products, sums, zero-w check
   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         for (int c = 0; c < 4; c++) begin
            p0_ff[c] <= $signed(mat[0][c]) * sx_ff;
            p1_ff[c] <= $signed(mat[1][c]) * sy_ff;
         end
         far_ff  <= far_in;
         near_ff <= near_in;
         entry_ff.far_sum  <= far_ff;
         entry_ff.near_sum <= near_ff;
         entry_ff.fault    <= (far_ff[3] == '0) || (near_ff[3] == '0);
      end
   end

endmodule

@@ rtl/spu_queue.sv @@
module spu_queue
   import spu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  wr_entry,
   input  logic       pop,
   output entry_type  rd_entry,
   output q_stat_type q_stat
);

   entry_type       mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]   count_ff;

   assign q_stat.full  = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_entry     = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_entry;
   end

endmodule

@@ rtl/spu_div.sv @@
module spu_div
   import spu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [SUM_W-1:0] num,
   input  logic [SUM_W-1:0] den,
   output logic [WORD_W-1:0] res
);

   localparam int DW = MAG_W + Q_BITS;

   logic [DW-1:0]     r_ff   [Q_BITS+1];
   logic [MAG_W-1:0]  d_ff   [Q_BITS+1];
   logic [Q_BITS-1:0] q_ff   [Q_BITS+1];
   logic              neg_ff [Q_BITS+1];
   logic              ovf_ff [Q_BITS+1];

   logic [MAG_W-1:0] un, ud;
   logic [DW-1:0]    n_in;

   // magnitudes and the scaled dividend
   assign un   = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
   assign ud   = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
   assign n_in = DW'(un) << FRAC_BITS;

   // first stage: quotient of 2^31 or more saturates
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= n_in;
         d_ff[0]   <= ud;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[SUM_W-1] ^ den[SUM_W-1];
         ovf_ff[0] <= n_in >= (DW'(ud) << Q_BITS);
      end
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
      localparam int SH = Q_BITS - k;
      logic [DW-1:0] dsh;
      logic          ge;
      assign dsh = DW'(d_ff[k-1]) << SH;
      assign ge  = r_ff[k-1] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge ? r_ff[k-1] - dsh : r_ff[k-1];
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (Q_BITS'(ge) << SH);
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // sign and saturation
   always_comb begin
      if (ovf_ff[Q_BITS])
         res = neg_ff[Q_BITS] ? SAT_NEG : SAT_POS;
      else if (neg_ff[Q_BITS])
         res = -{1'b0, q_ff[Q_BITS]};
      else
         res = {1'b0, q_ff[Q_BITS]};
   end

endmodule

@@ rtl/spu_back.sv @@
module spu_back
   import spu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             entry,
   input  q_stat_type            q_stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic                    en;
   logic                    v_ff [Q_BITS+1];
   logic                    f_ff [Q_BITS+1];
   logic [5:0][WORD_W-1:0]  lane_res;
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic                    rsp_tuser_ff;

   // the divider pipe moves whenever the output register is free
   assign en  = !rsp_tvalid_ff || rsp_tready;
   assign pop = en && !q_stat.empty;

   // lanes 0..2 near point (start), 3..5 far point (end)
   for (genvar c = 0; c < 3; c++) begin : g_lane
      spu_div #(.FRAC_BITS(FRAC_BITS)) u_near (
         .clock (clock),
         .en    (en),
         .num   (entry.near_sum[c]),
         .den   (entry.near_sum[3]),
         .res   (lane_res[c])
      );
      spu_div #(.FRAC_BITS(FRAC_BITS)) u_far (
         .clock (clock),
         .en    (en),
         .num   (entry.far_sum[c]),
         .den   (entry.far_sum[3]),
         .res   (lane_res[3+c])
      );
   end

   // valid and fault travel beside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Q_BITS; k++) v_ff[k] <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= !q_stat.empty;
         for (int k = 1; k <= Q_BITS; k++) v_ff[k] <= v_ff[k-1];
         rsp_tvalid_ff <= v_ff[Q_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff[0] <= entry.fault;
         for (int k = 1; k <= Q_BITS; k++) f_ff[k] <= f_ff[k-1];
         rsp_tdata_ff <= f_ff[Q_BITS] ? '0 : RSP_DATA_W'(lane_res);
         rsp_tuser_ff <= f_ff[Q_BITS];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ rtl/screen_point_unproject_ray.sv @@
// Screen point to world ray. A point (norm_x, norm_y, unsigned Q1.16) enters on
// the req_ stream; one result leaves on the rsp_ stream with the near point
// (start) and far point (end) divided by their w, in signed Q16.16, saturated.
// rsp_tuser is div_fault: a zero w gives all-zero coordinates.
// The inverse matrix is loaded over the csr_ port (index 0..7, 64-bit data);
// the user must load it while no transaction is in flight, which the block
// does not enforce; indexes 8 and up are dropped. A request passes through
// 4 front stages, one queue slot, 32 divider stages and the output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// six pipelined restoring dividers, one quotient bit per stage, set the depth.
// A 4-entry queue separates the multiply/sum front from the dividers.
// When rsp_tready is low while a result waits, the divider pipe holds, the
// queue fills, and then req_tready drops. Reset empties the pipes and the
// queue and clears the matrix to zero.
`include "screen_point_unproject_ray_assert.svh"

module screen_point_unproject_ray
   import spu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // csr write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // norm_x[16:0], norm_y[33:17], zero pad
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z
   output logic                  rsp_tuser   // div_fault
);

   logic [CSR_DATA_W-1:0] reg_ff [NUM_REGS];
   mat_type               mat;
   q_stat_type            q_stat;
   entry_type             f_entry, q_entry;
   logic                  push, pop;

   assign csr_ready = 1'b1;

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) reg_ff[i] <= '0;
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         reg_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // row r: columns 0/1 in register 2r, columns 2/3 in register 2r+1
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = reg_ff[2*r + c/2][(c%2)*WORD_W +: WORD_W];
         end
      end
   end

   spu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mat        (mat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .norm_x     (req_tdata[IN_W-1:0]),
      .norm_y     (req_tdata[2*IN_W-1:IN_W]),
      .q_stat     (q_stat),
      .push       (push),
      .entry      (f_entry)
   );

   spu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (f_entry),
      .pop      (pop),
      .rd_entry (q_entry),
      .q_stat   (q_stat)
   );

   spu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .entry      (q_entry),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // checks
   `SPU_ASSERT_NOW(a_queue_state, q_stat.full, !q_stat.empty)
   `SPU_ASSERT_NOW(a_fault_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `SPU_ASSERT_NEXT(a_full_stalls_front, q_stat.full && !pop, !q_stat.empty)

endmodule
